### rtl/qec_pkg.sv
// qec_pkg: shared types and constants of the quadrature encoder counter
// no dependencies; imported by the interfaces, the counter and its checker
`timescale 1ns / 1ps

package qec_pkg;

	// payload widths fixed by the item format
	localparam int unsigned QEC_FIELD_W     = 16;
	localparam int unsigned QEC_KIND_W      = 2;
	localparam int unsigned QEC_US_W        = 8;
	localparam int unsigned QEC_CFG_IDX_W   = 2;
	localparam int unsigned QEC_COUNT_WIDTH = 16;

	// item kinds; the fourth code means nothing and leaves the count alone
	localparam logic [QEC_KIND_W-1:0] KIND_A_EDGE = 2'd0;
	localparam logic [QEC_KIND_W-1:0] KIND_B_EDGE = 2'd1;
	localparam logic [QEC_KIND_W-1:0] KIND_QUERY  = 2'd2;

	// configuration register indexes
	localparam logic [QEC_CFG_IDX_W-1:0] REG_UNDERSAMPLE = 2'd0;
	localparam logic [QEC_CFG_IDX_W-1:0] REG_COUNT_MAX   = 2'd1;
	localparam logic [QEC_CFG_IDX_W-1:0] REG_COUNT_MIN   = 2'd2;

	// register reset values
	localparam logic [QEC_US_W-1:0]           UNDERSAMPLE_RST = 8'd7;
	localparam logic signed [QEC_FIELD_W-1:0] COUNT_MAX_RST   = 16'sd2048;
	localparam logic signed [QEC_FIELD_W-1:0] COUNT_MIN_RST   = -16'sd2048;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_DIV,
		ST_DONE
	} qec_state_t;

endpackage

### rtl/qec_if.sv
// qec_sample_if / qec_result_if: valid-ready channels of the encoder counter
// depends on qec_pkg for the field widths
`timescale 1ns / 1ps

interface qec_sample_if
	import qec_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [QEC_KIND_W-1:0] kind;
	logic                  a_level;
	logic                  b_level;

	modport source (output valid, output kind, output a_level, output b_level, input ready);
	modport sink   (input valid, input kind, input a_level, input b_level, output ready);
endinterface

interface qec_result_if
	import qec_pkg::*;
	();
	logic                          valid;
	logic                          ready;
	logic signed [QEC_FIELD_W-1:0] direction;
	logic signed [QEC_FIELD_W-1:0] position;

	modport source (output valid, output direction, output position, input ready);
	modport sink   (input valid, input direction, input position, output ready);
endinterface

### rtl/quadrature_encoder_counter.sv
// quadrature encoder counter: edge items step a wrapped position count, a query item
// divides it by undersample on one shared restoring divider, one quotient bit a cycle
// an edge item passes the step state, a query the serial divider loop, an unused kind goes to done
// one item at a time; sample.ready is high only while the sequencer is idle
// reset: arst_n clears count, pin history and the result valid flag; limits and undersample
// return to 2048, -2048 and 7; no clearing pass is needed
`timescale 1ns / 1ps

module quadrature_encoder_counter
	import qec_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = QEC_COUNT_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	qec_sample_if.sink               sample,
	qec_result_if.source             result,
	input  logic                     cfg_we,
	input  logic [QEC_CFG_IDX_W-1:0] cfg_index,
	input  logic [QEC_FIELD_W-1:0]   cfg_data
);

	// extended width for the step: holds the count and the 16-bit limits plus one bit
	localparam int unsigned EXT_W = ((COUNT_WIDTH > QEC_FIELD_W) ? COUNT_WIDTH : QEC_FIELD_W) + 1;
	localparam int unsigned BIT_W = $clog2(COUNT_WIDTH);

	qec_state_t state_q, state_d;

	// configuration
	logic [QEC_US_W-1:0]           undersample_q;
	logic signed [QEC_FIELD_W-1:0] count_max_q;
	logic signed [QEC_FIELD_W-1:0] count_min_q;

	// encoder state
	logic signed [COUNT_WIDTH-1:0] count_q;
	logic                          a_prev_q;
	logic                          b_last_q;

	// per-item control
	logic up_q;     // step direction of an edge item
	logic query_q;  // item is a query
	logic neg_q;    // sign of the count at query time

	// shared divider: dividend shifts out of quot_q while quotient bits shift in
	logic [COUNT_WIDTH-1:0] quot_q;
	logic [QEC_US_W-1:0]    rem_q;
	logic [BIT_W-1:0]       bit_q;

	// result register
	logic                          out_valid_q;
	logic signed [QEC_FIELD_W-1:0] direction_q;
	logic signed [QEC_FIELD_W-1:0] position_q;

	logic accept;
	logic load_out;
	logic us_write;

	assign accept   = sample.valid && sample.ready;
	assign us_write = cfg_we && (cfg_index == REG_UNDERSAMPLE);

	// next state and handshake
	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		load_out     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					priority if (sample.kind == KIND_A_EDGE || sample.kind == KIND_B_EDGE) begin
						state_d = ST_STEP;
					end else if (sample.kind == KIND_QUERY) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_STEP: begin
				state_d = ST_DONE;
			end
			ST_DIV: begin
				if (bit_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold the finished item until the result register frees up
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// step: +-1, then wrap above max to min, then below min to max, at full precision
	logic signed [EXT_W-1:0] step_v;
	logic signed [EXT_W-1:0] wrap_hi;
	logic signed [EXT_W-1:0] wrap_lo;
	logic signed [EXT_W-1:0] max_ext;
	logic signed [EXT_W-1:0] min_ext;

	always_comb begin
		max_ext = EXT_W'(count_max_q);
		min_ext = EXT_W'(count_min_q);
		step_v  = EXT_W'(count_q) + (up_q ? EXT_W'(1) : '1);
		wrap_hi = (step_v > max_ext) ? min_ext : step_v;
		wrap_lo = (wrap_hi < min_ext) ? max_ext : wrap_hi;
	end

	// divider step: bring down one dividend bit, subtract when it fits
	logic [QEC_US_W:0]   trial;
	logic                fits;
	logic [QEC_US_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quot_q[COUNT_WIDTH-1]};
		fits     = trial >= {1'b0, undersample_q};
		rem_next = fits ? QEC_US_W'(trial - {1'b0, undersample_q}) : trial[QEC_US_W-1:0];
	end

	// signed quotient and count magnitude
	logic signed [COUNT_WIDTH-1:0] quot_signed;
	logic [COUNT_WIDTH-1:0]        count_mag;
	logic                          quot_nz;

	always_comb begin
		quot_signed = neg_q ? -signed'(quot_q) : signed'(quot_q);
		count_mag   = count_q[COUNT_WIDTH-1] ? COUNT_WIDTH'(-count_q) : COUNT_WIDTH'(count_q);
		quot_nz     = quot_q != '0;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undersample_q <= UNDERSAMPLE_RST;
			count_max_q   <= COUNT_MAX_RST;
			count_min_q   <= COUNT_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UNDERSAMPLE: begin
					// zero is held as one
					undersample_q <= (cfg_data[QEC_US_W-1:0] == '0) ?
						QEC_US_W'(1) : cfg_data[QEC_US_W-1:0];
				end
				REG_COUNT_MAX: count_max_q <= signed'(cfg_data);
				REG_COUNT_MIN: count_min_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// encoder state; pin history updates on accept so the step sees the right xor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			a_prev_q <= 1'b0;
			b_last_q <= 1'b0;
		end else begin
			if (accept && sample.kind == KIND_A_EDGE) begin
				a_prev_q <= sample.a_level;
			end
			if (accept && sample.kind == KIND_B_EDGE) begin
				b_last_q <= sample.b_level;
			end
			priority if (us_write) begin
				count_q <= '0;
			end else if (state_q == ST_STEP) begin
				count_q <= wrap_lo[COUNT_WIDTH-1:0];
			end else if (load_out && query_q && quot_nz) begin
				// query with |count| >= undersample clears the count
				count_q <= '0;
			end
		end
	end

	// item control and divider registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q    <= 1'b0;
			query_q <= 1'b0;
			neg_q   <= 1'b0;
			bit_q   <= '0;
		end else if (accept) begin
			// b edge steps with the new b level, a edge with the old a level
			up_q    <= ((sample.kind == KIND_B_EDGE) ? sample.b_level : b_last_q) ^ a_prev_q;
			query_q <= sample.kind == KIND_QUERY;
			neg_q   <= count_q[COUNT_WIDTH-1];
			bit_q   <= BIT_W'(COUNT_WIDTH - 1);
		end else if (state_q == ST_DIV) begin
			bit_q <= bit_q - BIT_W'(1);
		end
	end

	// divider datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			quot_q <= count_mag;
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			quot_q <= {quot_q[COUNT_WIDTH-2:0], fits};
			rem_q  <= rem_next;
		end
	end

	// result register: parts the sequencer from the downstream ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (query_q) begin
				direction_q <= QEC_FIELD_W'(quot_signed);
				position_q  <= quot_nz ? '0 : QEC_FIELD_W'(count_q);
			end else begin
				direction_q <= '0;
				position_q  <= QEC_FIELD_W'(count_q);
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.direction = direction_q;
	assign result.position  = position_q;

endmodule

### rtl/qec_checker.sv
// qec_checker: port-level assertions for the quadrature encoder counter
// depends on qec_pkg; bound to quadrature_encoder_counter at the end of this file
`timescale 1ns / 1ps

module qec_checker
	import qec_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [QEC_FIELD_W-1:0] direction,
	input logic signed [QEC_FIELD_W-1:0] position
);

	// one item at a time: the sequencer leaves idle after every accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("qec: ready stayed high after an item was accepted");

	// no result can come out of the cycle right after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("qec: result appeared one cycle after accept");

	// a nonzero query result always clears the count
	a_query_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && direction != '0 |-> position == '0)
		else $error("qec: nonzero direction reported without clearing position");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(direction) && $stable(position))
		else $error("qec: stalled result changed");

endmodule

bind quadrature_encoder_counter qec_checker u_qec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.direction (result.direction),
	.position  (result.position)
);

### tb/quadrature_encoder_counter_test.sv
// quadrature_encoder_counter_test: self-checking bench for the encoder counter
// depends on qec_pkg, qec_sample_if / qec_result_if and the quadrature_encoder_counter rtl
`timescale 1ns / 1ps

module quadrature_encoder_counter_test;
	import qec_pkg::*;

	// the fourth kind code has no package name; the block must leave the count alone
	localparam logic [QEC_KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int IDLE_PERCENT = 13;

	typedef struct packed {
		logic [QEC_KIND_W-1:0] kind;
		logic                  a_level;
		logic                  b_level;
	} encoder_item_t;

	typedef struct packed {
		logic signed [QEC_FIELD_W-1:0] direction;
		logic signed [QEC_FIELD_W-1:0] position;
	} reading_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [QEC_CFG_IDX_W-1:0] cfg_index;
	logic [QEC_FIELD_W-1:0] cfg_data;

	qec_sample_if sample_ch ();
	qec_result_if result_ch ();

	quadrature_encoder_counter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// items waiting to be driven, and readings the block still owes us
	encoder_item_t pending_items[$];
	reading_t      expected_readings[$];
	encoder_item_t driven_item;

	int  queued_count;
	int  accepted_count;
	int  error_count;
	int  stall_cycles;
	bit  item_taken;
	bit  no_gaps;

	// shadow copy of the counter state and its registers
	logic [QEC_US_W-1:0]           divisor_setting;
	logic signed [QEC_FIELD_W-1:0] upper_limit;
	logic signed [QEC_FIELD_W-1:0] lower_limit;
	logic signed [QEC_FIELD_W-1:0] tracked_count;
	logic                          last_a;
	logic                          last_b;

	// pin levels of the simulated encoder shaft, kept apart from the shadow state
	logic walk_a;
	logic walk_b;
	bit   walk_forward;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// one count step: +1 when the pin history disagrees, -1 otherwise,
	// then the two wrap checks in order (they still run when the limits cross)
	function automatic void step_position();
		int v;
		v = tracked_count;
		v += (last_b ^ last_a) ? 1 : -1;
		if (v > upper_limit)
			v = lower_limit;
		if (v < lower_limit)
			v = upper_limit;
		tracked_count = v[QEC_FIELD_W-1:0];
	endfunction

	function automatic reading_t predict_reading(input encoder_item_t it);
		reading_t r;
		int divisor;
		int c;
		r.direction = '0;
		case (it.kind)
			KIND_A_EDGE: begin
				// a edge steps on the old a level, then records the new one
				step_position();
				last_a = it.a_level;
			end
			KIND_B_EDGE: begin
				// b edge records the new level first
				last_b = it.b_level;
				step_position();
			end
			KIND_QUERY: begin
				divisor = divisor_setting;
				c = tracked_count;
				// small counts are kept and report zero
				if (c >= divisor || c <= -divisor) begin
					r.direction = QEC_FIELD_W'(c / divisor);
					tracked_count = '0;
				end
			end
			default: begin
			end
		endcase
		r.position = tracked_count;
		return r;
	endfunction

	// checker and predictor share one edge: the older reading is checked
	// before the newly accepted item adds its own
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("unexpected result dir=%0d pos=%0d",
						result_ch.direction, result_ch.position));
				end else begin
					want = expected_readings.pop_front();
					if (result_ch.direction !== want.direction)
						report_mismatch($sformatf("direction %0d, expected %0d",
							result_ch.direction, want.direction));
					if (result_ch.position !== want.position)
						report_mismatch($sformatf("position %0d, expected %0d",
							result_ch.position, want.position));
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				expected_readings.push_back(predict_reading(
					{sample_ch.kind, sample_ch.a_level, sample_ch.b_level}));
				accepted_count++;
			end
		end
		item_taken <= sample_ch.valid && sample_ch.ready;
	end

	// driver: a held item stays on the bus until taken, new items go out
	// with random gaps unless a gap-free stretch is running
	always @(negedge clk) begin
		if (arst_n) begin
			if (!sample_ch.valid || item_taken) begin
				if (pending_items.size() != 0 &&
						(no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
					driven_item = pending_items.pop_front();
					sample_ch.valid   <= 1'b1;
					sample_ch.kind    <= driven_item.kind;
					sample_ch.a_level <= driven_item.a_level;
					sample_ch.b_level <= driven_item.b_level;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic queue_item(input logic [QEC_KIND_W-1:0] kind, input logic a,
			input logic b);
		encoder_item_t it;
		it.kind    = kind;
		it.a_level = a;
		it.b_level = b;
		pending_items.push_back(it);
		queued_count++;
	endtask

	// block idle: everything accepted and every reading back
	task automatic wait_idle();
		@(negedge clk);
		while (accepted_count != queued_count || expected_readings.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// register write, shadow updated once the write edge has passed
	task automatic write_reg(input logic [QEC_CFG_IDX_W-1:0] reg_index,
			input logic [QEC_FIELD_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= reg_index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (reg_index)
			REG_UNDERSAMPLE: begin
				// zero is held as one; the write clears the count
				divisor_setting = (data[QEC_US_W-1:0] == '0) ? QEC_US_W'(1) :
					data[QEC_US_W-1:0];
				tracked_count = '0;
			end
			REG_COUNT_MAX: upper_limit = data;
			REG_COUNT_MIN: lower_limit = data;
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [QEC_FIELD_W-1:0] us_data,
			input logic [QEC_FIELD_W-1:0] hi, input logic [QEC_FIELD_W-1:0] lo);
		write_reg(REG_UNDERSAMPLE, us_data);
		write_reg(REG_COUNT_MAX, hi);
		write_reg(REG_COUNT_MIN, lo);
		@(posedge clk);
	endtask

	// mostly a real shaft walk in gray order with runs in each direction,
	// mixed with queries and arbitrary items including the unused kind
	task automatic queue_walk(input int n);
		int roll;
		bit flip_a;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 10) begin
				queue_item(KIND_QUERY, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (roll < 18) begin
				queue_item(QEC_KIND_W'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else begin
				if ($urandom_range(99) < 10)
					walk_forward = !walk_forward;
				flip_a = walk_forward ? (walk_a == walk_b) : (walk_a != walk_b);
				if (flip_a) begin
					walk_a = !walk_a;
					queue_item(KIND_A_EDGE, walk_a, walk_b);
				end else begin
					walk_b = !walk_b;
					queue_item(KIND_B_EDGE, walk_a, walk_b);
				end
			end
		end
		wait_idle();
	endtask

	// random settings: mostly small divisors and narrow limits so wraps and
	// nonzero queries are frequent, sometimes anything the fields hold
	task automatic random_setup();
		int us;
		int hi;
		int lo;
		if ($urandom_range(3) == 0) begin
			us = $urandom_range(255);
			hi = int'($urandom_range(65535)) - 32768;
			lo = int'($urandom_range(65535)) - 32768;
		end else begin
			us = $urandom_range(12, 1);
			hi = $urandom_range(300);
			lo = 0 - int'($urandom_range(300));
		end
		configure(QEC_FIELD_W'(us), QEC_FIELD_W'(hi), QEC_FIELD_W'(lo));
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		sample_ch.valid   = 1'b0;
		sample_ch.kind    = KIND_A_EDGE;
		sample_ch.a_level = 1'b0;
		sample_ch.b_level = 1'b0;
		result_ch.ready   = 1'b0;
		item_taken        = 1'b0;
		no_gaps           = 1'b0;
		queued_count      = 0;
		accepted_count    = 0;
		error_count       = 0;
		stall_cycles      = 0;
		walk_a            = 1'b0;
		walk_b            = 1'b0;
		walk_forward      = 1'b1;
		// shadow state after reset
		divisor_setting   = UNDERSAMPLE_RST;
		upper_limit       = COUNT_MAX_RST;
		lower_limit       = COUNT_MIN_RST;
		tracked_count     = '0;
		last_a            = 1'b0;
		last_b            = 1'b0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset settings (divisor 7, limits +-2048)
		queue_item(KIND_QUERY, 1'b0, 1'b0);        // query of a zero count
		queue_item(KIND_A_EDGE, 1'b1, 1'b0);       // history agrees: step down
		queue_item(KIND_B_EDGE, 1'b0, 1'b1);
		queue_item(KIND_B_EDGE, 1'b1, 1'b0);       // history disagrees: step up
		queue_item(KIND_A_EDGE, 1'b0, 1'b0);
		queue_item(KIND_UNUSED, 1'b1, 1'b1);       // unused kind changes nothing
		repeat (8)
			queue_item(KIND_B_EDGE, 1'b0, 1'b1);   // climb to +8
		queue_item(KIND_QUERY, 1'b1, 1'b1);        // one detent, count cleared
		queue_item(KIND_QUERY, 1'b0, 1'b0);        // small query right after
		repeat (7)
			queue_item(KIND_B_EDGE, 1'b0, 1'b0);   // down to exactly -divisor
		queue_item(KIND_QUERY, 1'b0, 1'b1);
		queue_item(KIND_A_EDGE, 1'b1, 1'b1);
		wait_idle();

		// divisor written as zero with junk in the upper byte, tight wrap window
		configure(16'hFF00, 16'sd3, -16'sd3);
		queue_walk(150);

		// widest divisor, window pinned at the top of the range
		configure(16'd255, 16'sd32767, 16'sd32760);
		queue_walk(100);

		// divisor one, window pinned at the bottom: full-range query results
		configure(16'd1, -16'sd32761, -16'sd32768);
		queue_walk(100);

		// crossed limits
		configure(16'd4, -16'sd5, 16'sd5);
		queue_walk(100);

		// long stretch with no gaps on either side
		no_gaps = 1'b1;
		configure(16'd3, 16'sd20, -16'sd20);
		queue_walk(200);
		no_gaps = 1'b0;

		// full signed range
		configure(16'd16, 16'sd32767, -16'sd32768);
		queue_walk(200);

		repeat (4) begin
			random_setup();
			queue_walk(60);
		end

		// let any stray result show up before the verdict
		repeat (30) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
